// File: hdl/alr_pkg.sv
`timescale 1ns / 1ps

package alr_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 18;
  localparam int PIX_W     = 12;
  localparam int COV_W     = 9;
  localparam int COLOR_W   = 16;
  localparam int SLOPE_W   = 10;
  localparam int YPOS_W    = 20;
  localparam int COL_W     = COORD_W - FRAC_BITS + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(QUO_W);
  localparam int OFF_W     = FRAC_BITS + 1;
  localparam int PROD_W    = SLOPE_W + OFF_W;

  localparam logic [COV_W-1:0]   ONE_UNIT  = COV_W'(1 << FRAC_BITS);
  localparam logic [COV_W-1:0]   HALF_UNIT = COV_W'(1 << (FRAC_BITS - 1));
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(QUO_W - 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SLOPE,
    ST_MUL,
    ST_FIN,
    ST_OUT0,
    ST_OUT1
  } alr_state_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_SECOND,
    PH_COLS
  } alr_phase_e;

  typedef struct packed {
    logic load_line;
    logic div_step;
    logic load_slope;
    logic load_prod;
    logic load_ends;
    logic load_pair;
    logic sel_second;
  } alr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic line_active;
  } alr_stat_t;

endpackage

// File: hdl/alr_if.sv
`timescale 1ns / 1ps

interface alr_in_if;
  import alr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [COORD_W-1:0]   start_x;
  logic [COORD_W-1:0]   start_y;
  logic [COORD_W-1:0]   end_x;
  logic [COORD_W-1:0]   end_y;
  logic [COLOR_W-1:0]   line_color;

  modport source (output valid, func, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, func, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

interface alr_out_if;
  import alr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PIX_W-1:0]  pixel_x;
  logic signed [PIX_W-1:0]  pixel_y;
  logic [COV_W-1:0]         coverage;
  logic [COLOR_W-1:0]       plot_color;
  logic                     pair_last;
  logic                     line_done;

  modport source (output valid, pixel_x, pixel_y, coverage, plot_color, pair_last,
                  line_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, coverage, plot_color, pair_last,
                line_done, output ready);
endinterface

// File: hdl/alr_ctrl.sv
`timescale 1ns / 1ps

module alr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_func_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  alr_pkg::alr_stat_t stat_i,
  output alr_pkg::alr_cmd_t  cmd_o
);
  import alr_pkg::*;

  alr_state_e state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_START) begin
            state_d = ST_DIV;
          end else if (stat_i.line_active) begin
            state_d = ST_OUT0;
          end
        end
      end
      ST_DIV: begin
        if (stat_i.div_last) begin
          state_d = ST_SLOPE;
        end
      end
      ST_SLOPE: state_d = ST_MUL;
      ST_MUL:   state_d = ST_FIN;
      ST_FIN:   state_d = ST_IDLE;
      ST_OUT0: begin
        if (out_ready_i) begin
          state_d = ST_OUT1;
        end
      end
      ST_OUT1: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load_line = accept && (in_func_i == FUNC_START);
        cmd_o.load_pair = accept && (in_func_i == FUNC_STEP) && stat_i.line_active;
      end
      ST_DIV:   cmd_o.div_step   = 1'b1;
      ST_SLOPE: cmd_o.load_slope = 1'b1;
      ST_MUL:   cmd_o.load_prod  = 1'b1;
      ST_FIN:   cmd_o.load_ends  = 1'b1;
      ST_OUT0:  out_valid_o      = 1'b1;
      ST_OUT1: begin
        out_valid_o      = 1'b1;
        cmd_o.sel_second = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("input taken while a plot word is pending");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT0) && out_ready_i |=> (state_q == ST_OUT1))
    else $error("second plot of a pair did not follow the first");

  a_step_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_pair |=> (state_q == ST_OUT0))
    else $error("pair loaded without being presented");

endmodule

// File: hdl/alr_dp.sv
`timescale 1ns / 1ps

module alr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  alr_pkg::alr_cmd_t             cmd_i,
  output alr_pkg::alr_stat_t            stat_o,
  input  logic [alr_pkg::COORD_W-1:0]   start_x_i,
  input  logic [alr_pkg::COORD_W-1:0]   start_y_i,
  input  logic [alr_pkg::COORD_W-1:0]   end_x_i,
  input  logic [alr_pkg::COORD_W-1:0]   end_y_i,
  input  logic [alr_pkg::COLOR_W-1:0]   line_color_i,
  output logic signed [alr_pkg::PIX_W-1:0] pixel_x_o,
  output logic signed [alr_pkg::PIX_W-1:0] pixel_y_o,
  output logic [alr_pkg::COV_W-1:0]     coverage_o,
  output logic [alr_pkg::COLOR_W-1:0]   plot_color_o,
  output logic                          pair_last_o,
  output logic                          line_done_o
);
  import alr_pkg::*;

  // Line setup: major/minor axis endpoints after the steep swap and ordering.
  logic signed [COORD_W:0] dx, dy, dmaj, dmin;
  logic [COORD_W-1:0]      adx, ady;
  logic                    steep_w, order_swap;
  logic [COORD_W-1:0]      a1, b1, a2, b2;

  logic [COORD_W-1:0] maj1_q, min1_q, maj2_q, min2_q;
  logic [COORD_W-1:0] den_q, rem_q, rem_d;
  logic [QUO_W-1:0]   quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               neg_q, dz_q, steep_q;
  logic [COLOR_W-1:0] color_q;

  logic [COORD_W:0]   cand;
  logic               ge;

  logic signed [SLOPE_W-1:0] slope_q, slope_d;
  logic [COORD_W:0]          h1, h2;
  logic signed [OFF_W-1:0]   off1, off2;
  logic signed [PROD_W-1:0]  prod1_q, prod2_q, pr1, pr2;

  logic signed [YPOS_W-1:0] fey_q, sey_q, yint_q, fey_d, sey_d, slope_ext;
  logic [COV_W-1:0]         gap1_q, gap2_q;
  logic [COL_W-1:0]         column_q, last_q, col_next;
  alr_phase_e               phase_q;
  logic                     cols_done;

  logic signed [YPOS_W-1:0] y_sel;
  logic [COV_W-1:0]         gap_sel;
  logic [COL_W-1:0]         col_sel;
  logic                     done_sel;
  logic [FRAC_BITS-1:0]     f;
  logic signed [PIX_W-1:0]  row0, row1, col12;
  logic [COV_W-1:0]         w0;
  logic [2*COV_W-1:0]       m0, m1;

  logic signed [PIX_W-1:0]  p0_x_q, p0_y_q, p1_x_q, p1_y_q;
  logic [COV_W-1:0]         p0_cov_q, p1_cov_q;
  logic                     p1_done_q;

  always_comb begin
    dx      = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dy      = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
    adx     = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady     = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steep_w = adx < ady;
    dmaj    = steep_w ? dy : dx;
    dmin    = steep_w ? dx : dy;
    a1      = steep_w ? start_y_i : start_x_i;
    b1      = steep_w ? start_x_i : start_y_i;
    a2      = steep_w ? end_y_i : end_x_i;
    b2      = steep_w ? end_x_i : end_y_i;
    order_swap = a2 < a1;
  end

  // Restoring divider for |dmin| * 256 / |dmaj|; the quotient never exceeds 256.
  always_comb begin
    cand  = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge    = cand >= {1'b0, den_q};
    rem_d = ge ? COORD_W'(cand - {1'b0, den_q}) : cand[COORD_W-1:0];
  end

  always_comb begin
    slope_d = dz_q ? '0 :
              (neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));
  end

  always_comb begin
    h1   = {1'b0, maj1_q} + (COORD_W+1)'(HALF_UNIT);
    h2   = {1'b0, maj2_q} + (COORD_W+1)'(HALF_UNIT);
    off1 = $signed(HALF_UNIT - {1'b0, h1[FRAC_BITS-1:0]});
    off2 = $signed(HALF_UNIT - {1'b0, h2[FRAC_BITS-1:0]});
  end

  // Signed division by 256 truncating toward zero: bias negative products first.
  always_comb begin
    pr1       = prod1_q + $signed({{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{prod1_q[PROD_W-1]}}});
    pr2       = prod2_q + $signed({{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{prod2_q[PROD_W-1]}}});
    fey_d     = $signed({2'b00, min1_q})
              + $signed({{(YPOS_W-PROD_W+FRAC_BITS){pr1[PROD_W-1]}}, pr1[PROD_W-1:FRAC_BITS]});
    sey_d     = $signed({2'b00, min2_q})
              + $signed({{(YPOS_W-PROD_W+FRAC_BITS){pr2[PROD_W-1]}}, pr2[PROD_W-1:FRAC_BITS]});
    slope_ext = $signed({{(YPOS_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q});
  end

  always_comb begin
    col_next  = column_q + COL_W'(1);
    cols_done = col_next >= last_q;
    y_sel     = yint_q;
    gap_sel   = ONE_UNIT;
    col_sel   = column_q;
    done_sel  = cols_done;
    case (phase_q)
      PH_FIRST: begin
        y_sel    = fey_q;
        gap_sel  = gap1_q;
        done_sel = 1'b0;
      end
      PH_SECOND: begin
        y_sel   = sey_q;
        gap_sel = gap2_q;
        col_sel = last_q;
      end
      default: begin
        y_sel = yint_q;
      end
    endcase
    f     = y_sel[FRAC_BITS-1:0];
    row0  = y_sel[YPOS_W-1:FRAC_BITS];
    row1  = row0 + PIX_W'(1);
    col12 = $signed({{(PIX_W-COL_W){1'b0}}, col_sel});
    w0    = ONE_UNIT - {1'b0, f};
    m0    = {{COV_W{1'b0}}, w0} * {{COV_W{1'b0}}, gap_sel};
    m1    = {{(COV_W+1){1'b0}}, f} * {{COV_W{1'b0}}, gap_sel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.load_line) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + CNT_W'(1);
      end
      if (cmd_i.load_ends) begin
        phase_q <= PH_FIRST;
      end else if (cmd_i.load_pair) begin
        case (phase_q)
          PH_FIRST:  phase_q <= PH_SECOND;
          PH_SECOND: phase_q <= cols_done ? PH_IDLE : PH_COLS;
          PH_COLS:   phase_q <= cols_done ? PH_IDLE : PH_COLS;
          default:   phase_q <= PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      maj1_q  <= order_swap ? a2 : a1;
      min1_q  <= order_swap ? b2 : b1;
      maj2_q  <= order_swap ? a1 : a2;
      min2_q  <= order_swap ? b1 : b2;
      den_q   <= steep_w ? ady : adx;
      rem_q   <= steep_w ? adx : ady;
      neg_q   <= dmaj[COORD_W] ^ dmin[COORD_W];
      dz_q    <= (steep_w ? ady : adx) == '0;
      steep_q <= steep_w;
      color_q <= line_color_i;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
    if (cmd_i.load_slope) begin
      slope_q <= slope_d;
    end
    if (cmd_i.load_prod) begin
      prod1_q <= slope_q * off1;
      prod2_q <= slope_q * off2;
    end
    if (cmd_i.load_ends) begin
      fey_q    <= fey_d;
      sey_q    <= sey_d;
      yint_q   <= fey_d + slope_ext;
      gap1_q   <= ONE_UNIT - {1'b0, h1[FRAC_BITS-1:0]};
      gap2_q   <= {1'b0, h2[FRAC_BITS-1:0]};
      column_q <= h1[COORD_W:FRAC_BITS];
      last_q   <= h2[COORD_W:FRAC_BITS];
    end
    if (cmd_i.load_pair) begin
      p0_x_q    <= steep_q ? row0 : col12;
      p0_y_q    <= steep_q ? col12 : row0;
      p1_x_q    <= steep_q ? row1 : col12;
      p1_y_q    <= steep_q ? col12 : row1;
      p0_cov_q  <= m0[FRAC_BITS+COV_W-1:FRAC_BITS];
      p1_cov_q  <= m1[FRAC_BITS+COV_W-1:FRAC_BITS];
      p1_done_q <= done_sel;
      if (phase_q != PH_FIRST) begin
        column_q <= col_next;
      end
      if (phase_q == PH_COLS) begin
        yint_q <= yint_q + slope_ext;
      end
    end
  end

  assign stat_o.div_last    = (cnt_q == DIV_LAST);
  assign stat_o.line_active = (phase_q != PH_IDLE);

  assign pixel_x_o    = cmd_i.sel_second ? p1_x_q : p0_x_q;
  assign pixel_y_o    = cmd_i.sel_second ? p1_y_q : p0_y_q;
  assign coverage_o   = cmd_i.sel_second ? p1_cov_q : p0_cov_q;
  assign plot_color_o = color_q;
  assign pair_last_o  = cmd_i.sel_second;
  assign line_done_o  = cmd_i.sel_second && p1_done_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DIV_LAST)
    else $error("divider step count out of range");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load_ends && !cmd_i.load_pair |=> $stable(phase_q))
    else $error("line phase moved without a start or step");

endmodule

// File: hdl/antialiased_line_rasterizer.sv
`timescale 1ns / 1ps

// Wu anti-aliased line rasterizer on 10.8 fixed-point endpoints. A start word
// (func 0) latches a line and returns nothing; after acceptance it runs the
// restoring slope divider, which produces one quotient bit per cycle, then the
// slope, multiply and endpoint stages. Each step word (func 1) returns two plot
// words: the two pixels of the first endpoint, then of the second, then one pair
// per interior column, with line_done on the last. The pair leaves through two
// output registers, one word per cycle while the sink is ready, and no new word
// is accepted until both plot words have been taken. A step with no line in
// progress is taken and dropped.
module antialiased_line_rasterizer (
  input logic        clk_i,
  input logic        rst_ni,
  alr_in_if.sink     line_i,
  alr_out_if.source  plot_o
);
  import alr_pkg::*;

  alr_cmd_t  cmd;
  alr_stat_t stat;

  alr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (line_i.valid),
    .in_func_i   (line_i.func),
    .in_ready_o  (line_i.ready),
    .out_valid_o (plot_o.valid),
    .out_ready_i (plot_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  alr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .start_x_i    (line_i.start_x),
    .start_y_i    (line_i.start_y),
    .end_x_i      (line_i.end_x),
    .end_y_i      (line_i.end_y),
    .line_color_i (line_i.line_color),
    .pixel_x_o    (plot_o.pixel_x),
    .pixel_y_o    (plot_o.pixel_y),
    .coverage_o   (plot_o.coverage),
    .plot_color_o (plot_o.plot_color),
    .pair_last_o  (plot_o.pair_last),
    .line_done_o  (plot_o.line_done)
  );

endmodule
